### hw/rtl/gbcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbcc_pkg;

    // Number of summed samples in one calibration run.
    localparam int CAL_SAMPLES = 256;

    // Width of one raw gyro axis.
    localparam int SMP_W   = 16;
    localparam int AXES    = 3;

    // floor(log2(CAL_SAMPLES)): the bias is the run sum shifted right by this.
    localparam int CAL_SHIFT = $clog2(CAL_SAMPLES + 1) - 1;

    // The sum holds CAL_SAMPLES signed samples without overflow.
    localparam int SUM_W  = SMP_W + $clog2(CAL_SAMPLES);

    // Bias width; equals SMP_W when CAL_SAMPLES is a power of two.
    localparam int BIAS_W = SUM_W - CAL_SHIFT;

    // Sample counter inside a run; it counts 0 .. CAL_SAMPLES-1.
    localparam int CNT_W  = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;

    localparam int SPREAD_W = 16;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [BIAS_W-1:0] t_bias;

    // Calibration status codes.
    localparam logic [1:0] CAL_NONE   = 2'd0;
    localparam logic [1:0] CAL_OK     = 2'd1;
    localparam logic [1:0] CAL_REJECT = 2'd2;

    typedef struct packed {
        logic       calibrating;
        logic [1:0] status;
    } t_cal_res;

endpackage

`default_nettype wire

### hw/rtl/gbcc_corr.sv
`timescale 1ns / 1ps
`default_nettype none

// Subtracts the per-axis bias and saturates to the sample width; a start item gives zero rates.
module gbcc_corr
    import gbcc_pkg::*;
(
    input  wire logic  i_start,
    input  wire t_smp  i_raw  [AXES],
    input  wire t_bias i_bias [AXES],
    output t_smp       o_rate [AXES]
);

    localparam int DIFF_W = BIAS_W + 1;

    logic [DIFF_W-1:0] w_diff [AXES];
    logic [DIFF_W-SMP_W:0] w_top [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_diff[i] = {{(DIFF_W-SMP_W){i_raw[i][SMP_W-1]}}, i_raw[i]}
                      - {i_bias[i][BIAS_W-1], i_bias[i]};
            w_top[i]  = w_diff[i][DIFF_W-1:SMP_W-1];
            if (i_start) begin
                o_rate[i] = '0;
            end else if ((&w_top[i]) || !(|w_top[i])) begin
                o_rate[i] = w_diff[i][SMP_W-1:0];
            end else if (w_diff[i][DIFF_W-1]) begin
                o_rate[i] = {1'b1, {(SMP_W-1){1'b0}}};
            end else begin
                o_rate[i] = {1'b0, {(SMP_W-1){1'b1}}};
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gbcc_cal.sv
`timescale 1ns / 1ps
`default_nettype none

// Calibration sequencer: holds the bias, the run sums, the per-axis extremes,
// the spread limit and the run phase. One item is processed per i_step.
module gbcc_cal
    import gbcc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [SPREAD_W-1:0] i_cfg_data,
    input  wire logic                i_step,
    input  wire logic                i_start,
    input  wire t_smp                i_raw  [AXES],
    output t_bias                    o_bias [AXES],
    output t_cal_res                 o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEED,
        PH_COLLECT
    } t_phase;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAL_SAMPLES - 1);

    t_phase              r_phase;
    logic [CNT_W-1:0]    r_count;
    logic [SPREAD_W-1:0] r_max_spread;
    t_bias               r_bias [AXES];
    logic [SUM_W-1:0]    r_sum  [AXES];
    t_smp                r_min  [AXES];
    t_smp                r_max  [AXES];

    t_smp                n_min  [AXES];
    t_smp                n_max  [AXES];
    logic [SUM_W-1:0]    n_sum  [AXES];
    logic [SMP_W:0]      w_spread [AXES];
    logic                w_bad;
    logic                w_last;

    always_comb begin
        w_bad = 1'b0;
        for (int i = 0; i < AXES; i++) begin
            n_min[i] = (i_raw[i] < r_min[i]) ? i_raw[i] : r_min[i];
            n_max[i] = (i_raw[i] > r_max[i]) ? i_raw[i] : r_max[i];
            n_sum[i] = r_sum[i] + {{(SUM_W-SMP_W){i_raw[i][SMP_W-1]}}, i_raw[i]};
            w_spread[i] = {n_max[i][SMP_W-1], n_max[i]} - {n_min[i][SMP_W-1], n_min[i]};
            if (w_spread[i] > {1'b0, r_max_spread}) begin
                w_bad = 1'b1;
            end
        end
        w_last = (r_count == LAST_CNT);
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            o_bias[i] = r_bias[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_count      <= '0;
            r_max_spread <= SPREAD_W'(256);
            for (int i = 0; i < AXES; i++) begin
                r_bias[i] <= '0;
                r_sum[i]  <= '0;
            end
            o_res        <= '{calibrating: 1'b0, status: CAL_NONE};
        end else begin
            if (i_cfg_we) begin
                r_max_spread <= i_cfg_data;
            end
            if (i_step) begin
                if (i_start) begin
                    r_phase <= PH_SEED;
                    r_count <= '0;
                    for (int i = 0; i < AXES; i++) begin
                        r_sum[i] <= '0;
                    end
                    o_res <= '{calibrating: 1'b1, status: CAL_NONE};
                end else begin
                    unique case (r_phase)
                        PH_SEED: begin
                            for (int i = 0; i < AXES; i++) begin
                                r_min[i] <= i_raw[i];
                                r_max[i] <= i_raw[i];
                            end
                            r_phase <= PH_COLLECT;
                            o_res   <= '{calibrating: 1'b1, status: CAL_NONE};
                        end
                        PH_COLLECT: begin
                            for (int i = 0; i < AXES; i++) begin
                                r_min[i] <= n_min[i];
                                r_max[i] <= n_max[i];
                                r_sum[i] <= n_sum[i];
                            end
                            if (w_last) begin
                                if (!w_bad) begin
                                    for (int i = 0; i < AXES; i++) begin
                                        r_bias[i] <= n_sum[i][SUM_W-1:CAL_SHIFT];
                                    end
                                end
                                r_phase <= PH_IDLE;
                                r_count <= '0;
                                o_res   <= '{calibrating: 1'b0,
                                             status: w_bad ? CAL_REJECT : CAL_OK};
                            end else begin
                                r_count <= r_count + 1'b1;
                                o_res   <= '{calibrating: 1'b1, status: CAL_NONE};
                            end
                        end
                        default: begin
                            o_res <= '{calibrating: 1'b0, status: CAL_NONE};
                        end
                    endcase
                end
            end
        end
    end

    // The counter is cleared whenever a run is not collecting.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_COLLECT) |-> (r_count == '0))
        else $error("run counter not cleared outside a collecting run");

    // A start item always moves the sequencer to the seed phase.
    a_start_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_start) |=> (r_phase == PH_SEED && r_count == '0))
        else $error("start item did not restart the run");

endmodule

`default_nettype wire

### hw/rtl/gyro_bias_calibrate_correct.sv
`timescale 1ns / 1ps
`default_nettype none

// Gyro bias calibration and correction. Every transaction on the slave side
// yields exactly one transaction on the master side, in order. A gyro sample
// (tuser = 0) comes back as each axis minus the stored bias, saturated to
// 16 bits. A start item (tuser = 1) begins a calibration run: the next sample
// seeds the per-axis minimum and maximum, and the CAL_SAMPLES samples after
// it are summed. On the last of them the peak-to-peak spread of every axis is
// checked against max_spread; if all pass the bias becomes each sum shifted
// right by floor(log2(CAL_SAMPLES)), otherwise the old bias is kept. That
// last sample is still corrected with the old bias and reports the outcome
// in cal_status. The block takes one item per clock cycle while the output
// side is not stalled; each result passes an input register, the
// correction and calibration update in one combinational pass, and an
// output register that decouples the two sides. The bias state is ready
// right out of reset, with no clearing pass. The configuration channel is
// always ready and should only be written while no items are in flight.
module gyro_bias_calibrate_correct
    import gbcc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Configuration: max_spread.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,

    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [15:0] gyro_x_raw, [31:16] gyro_y_raw, [47:32] gyro_z_raw
    input  wire logic [47:0] i_s_axis_tdata,
    // [0] func (1 = start calibration)
    input  wire logic        i_s_axis_tuser,

    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] rate_x, [31:16] rate_y, [47:32] rate_z
    output logic [47:0]      o_m_axis_tdata,
    // [0] calibrating, [2:1] cal_status
    output logic [2:0]       o_m_axis_tuser
);

    // Input register stage.
    logic  r_in_valid;
    logic  r_in_start;
    t_smp  r_in_raw [AXES];

    // Output register stage; the calibration flags are registered in gbcc_cal.
    logic  r_out_valid;
    t_smp  r_out_rate [AXES];

    logic     w_adv;
    t_bias    w_bias [AXES];
    t_smp     w_rate [AXES];
    t_cal_res w_res;

    // The input stage moves on whenever the output register is empty or
    // its contents are being taken in this cycle.
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_start <= i_s_axis_tuser;
            for (int i = 0; i < AXES; i++) begin
                r_in_raw[i] <= i_s_axis_tdata[i*SMP_W +: SMP_W];
            end
        end
    end

    gbcc_corr u_corr (
        .i_start (r_in_start),
        .i_raw   (r_in_raw),
        .i_bias  (w_bias),
        .o_rate  (w_rate)
    );

    gbcc_cal u_cal (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_adv),
        .i_start    (r_in_start),
        .i_raw      (r_in_raw),
        .o_bias     (w_bias),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < AXES; i++) begin
                r_out_rate[i] <= w_rate[i];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_rate[2], r_out_rate[1], r_out_rate[0]};
    assign o_m_axis_tuser  = {w_res.status, w_res.calibrating};

    // A run outcome is only reported on the sample that ends the run.
    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[2:1] != CAL_NONE) |-> !o_m_axis_tuser[0])
        else $error("calibration outcome reported while still calibrating");

    // A start item comes out as zero rates with the calibrating flag set.
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_start) |=>
            (o_m_axis_tvalid && o_m_axis_tuser == {CAL_NONE, 1'b1}
             && o_m_axis_tdata == '0))
        else $error("start item result is wrong");

    // An item leaving the input stage always lands in the output register.
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_axis_tvalid)
        else $error("item lost between input and output registers");

endmodule

`default_nettype wire

### tb/gyro_func_pkg.sv
`timescale 1ns / 1ps

package gyro_func_pkg;

    // Item kinds carried in the slave-side tuser.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_START  = 1'b1;

endpackage

### tb/gyro_rate_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the bias block and predicts every result.
module gyro_rate_checker
    import gbcc_pkg::*;
    import gyro_func_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [SPREAD_W-1:0]   i_cfg_data,

    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [AXES*SMP_W-1:0] i_s_tdata,
    input  wire logic                  i_s_tuser,

    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [AXES*SMP_W-1:0] i_m_tdata,
    input  wire logic [2:0]            i_m_tuser,

    output int                         o_outstanding,
    output int                         o_errors
);

    localparam logic [SPREAD_W-1:0] SPREAD_AT_RESET = 16'd256;
    localparam int RATE_MAX = 2 ** (SMP_W - 1) - 1;
    localparam int RATE_MIN = -(2 ** (SMP_W - 1));

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_SEED,
        RUN_COLLECT
    } t_run_phase;

    typedef struct packed {
        t_smp       rate_z;
        t_smp       rate_y;
        t_smp       rate_x;
        logic       calibrating;
        logic [1:0] status;
    } t_rate_out;

    t_bias                   bias_now [AXES];
    logic signed [SUM_W-1:0] run_sum [AXES];
    t_smp                    run_min [AXES];
    t_smp                    run_max [AXES];
    int                      run_len;
    t_run_phase              run_phase;
    logic [SPREAD_W-1:0]     spread_limit;
    t_rate_out               expected_rates [$];
    int                      mismatch_count;

    // Corrects one item and advances the calibration run it belongs to.
    function automatic t_rate_out predict_rate(logic func, logic [AXES*SMP_W-1:0] data);
        t_rate_out r;
        t_smp      raw [AXES];
        t_smp      rate [AXES];
        int        diff;
        logic      too_wide;
        r = '0;
        too_wide = 1'b0;
        if (func == FUNC_START) begin
            for (int a = 0; a < AXES; a++) begin
                run_sum[a] = '0;
            end
            run_len = 0;
            run_phase = RUN_SEED;
            r.calibrating = 1'b1;
            r.status = CAL_NONE;
            return r;
        end
        for (int a = 0; a < AXES; a++) begin
            raw[a] = t_smp'(data[a*SMP_W +: SMP_W]);
            diff = int'(raw[a]) - int'(bias_now[a]);
            if (diff > RATE_MAX) begin
                diff = RATE_MAX;
            end else if (diff < RATE_MIN) begin
                diff = RATE_MIN;
            end
            rate[a] = t_smp'(diff);
        end
        r.status = CAL_NONE;
        case (run_phase)
            RUN_SEED: begin
                for (int a = 0; a < AXES; a++) begin
                    run_min[a] = raw[a];
                    run_max[a] = raw[a];
                end
                run_phase = RUN_COLLECT;
            end
            RUN_COLLECT: begin
                for (int a = 0; a < AXES; a++) begin
                    run_sum[a] = run_sum[a] + raw[a];
                    if (raw[a] < run_min[a]) run_min[a] = raw[a];
                    if (raw[a] > run_max[a]) run_max[a] = raw[a];
                end
                run_len++;
                if (run_len >= CAL_SAMPLES) begin
                    for (int a = 0; a < AXES; a++) begin
                        if (int'(run_max[a]) - int'(run_min[a]) > int'(spread_limit))
                            too_wide = 1'b1;
                    end
                    if (too_wide) begin
                        r.status = CAL_REJECT;
                    end else begin
                        // The mean rounds toward minus infinity.
                        for (int a = 0; a < AXES; a++) begin
                            bias_now[a] = t_bias'(run_sum[a] >>> CAL_SHIFT);
                        end
                        r.status = CAL_OK;
                    end
                    run_phase = RUN_IDLE;
                    run_len = 0;
                end
            end
            default: begin
                run_phase = RUN_IDLE;
            end
        endcase
        r.rate_x = rate[0];
        r.rate_y = rate[1];
        r.rate_z = rate[2];
        r.calibrating = (run_phase != RUN_IDLE);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rate_out want;
        t_rate_out got;
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                bias_now[a] = '0;
                run_sum[a] = '0;
                run_min[a] = '0;
                run_max[a] = '0;
            end
            run_len = 0;
            run_phase = RUN_IDLE;
            spread_limit = SPREAD_AT_RESET;
            expected_rates.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                spread_limit = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_rates.push_back(predict_rate(i_s_tuser, i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.rate_x = t_smp'(i_m_tdata[0*SMP_W +: SMP_W]);
                got.rate_y = t_smp'(i_m_tdata[1*SMP_W +: SMP_W]);
                got.rate_z = t_smp'(i_m_tdata[2*SMP_W +: SMP_W]);
                got.calibrating = i_m_tuser[0];
                got.status = i_m_tuser[2:1];
                if (expected_rates.size() == 0) begin
                    $error("result transaction with no item waiting for it");
                    mismatch_count++;
                end else begin
                    want = expected_rates.pop_front();
                    if (got.rate_x != want.rate_x) begin
                        $error("rate_x: expected %0d, got %0d", want.rate_x, got.rate_x);
                        mismatch_count++;
                    end
                    if (got.rate_y != want.rate_y) begin
                        $error("rate_y: expected %0d, got %0d", want.rate_y, got.rate_y);
                        mismatch_count++;
                    end
                    if (got.rate_z != want.rate_z) begin
                        $error("rate_z: expected %0d, got %0d", want.rate_z, got.rate_z);
                        mismatch_count++;
                    end
                    if (got.calibrating != want.calibrating) begin
                        $error("calibrating: expected %0d, got %0d",
                               want.calibrating, got.calibrating);
                        mismatch_count++;
                    end
                    if (got.status != want.status) begin
                        $error("cal_status: expected %0d, got %0d", want.status, got.status);
                        mismatch_count++;
                    end
                end
            end
        end
        o_outstanding <= expected_rates.size();
        o_errors <= mismatch_count;
    end

endmodule

### tb/gyro_bias_calibrate_correct_test.sv
`timescale 1ns / 1ps

// Drives the bias block with directed items and then with whole calibration
// runs, one per phase, each under its own max_spread and its own pattern of
// idle and stall cycles. The checker beside the block predicts and compares.
module gyro_bias_calibrate_correct_test;

    import gbcc_pkg::*;
    import gyro_func_pkg::*;

    // Watchdog limit, set well above what the slowest correct run needs.
    localparam int CYCLE_LIMIT = 200000;
    // Longest idle stretch that the sender inserts before one transaction.
    localparam int MAX_GAP     = 20;
    localparam int RAW_MAX     = 2 ** (SMP_W - 1) - 1;
    localparam int RAW_MIN     = -(2 ** (SMP_W - 1));

    // How the samples of one calibration run are spread on each axis.
    typedef enum int {
        RUN_FLAT_EXTREME,   // every sample at one end of the range
        RUN_WITHIN,         // spread exactly max_spread, so the run passes
        RUN_OVER,           // one axis one count wider than max_spread
        RUN_FULL_SWING      // every axis spans the whole range
    } t_run_shape;

    // Where a run gets started over before it completes.
    typedef enum int {
        RESTART_NONE,
        RESTART_EARLY,      // after zero to twelve samples
        RESTART_LATE        // one sample short of the end of the run
    } t_restart;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SPREAD_W-1:0]   cfg_data = '0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [AXES*SMP_W-1:0] s_tdata = '0;
    logic                  s_tuser = FUNC_SAMPLE;

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [AXES*SMP_W-1:0] m_tdata;
    logic [2:0]            m_tuser;

    int                    outstanding;
    int                    mismatches;
    int                    cycles = 0;

    // Idling of each side, in cycles out of a hundred.
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;
    // The max_spread value last written, used to shape the runs.
    logic [SPREAD_W-1:0]   spread_setting = 16'd256;

    always #5 clk = ~clk;

    gyro_bias_calibrate_correct dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    gyro_rate_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_outstanding (outstanding),
        .o_errors      (mismatches)
    );

    // The receiver stalls on a fresh random draw every cycle.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("gyro_bias_calibrate_correct_test: done, errors");
            $finish;
        end
    end

    // Presents one item, after a random idle stretch, and returns in the time
    // step of the edge where its transaction completes. All signals change
    // only through nonblocking assignments, so the values read right after
    // the edge are the ones the block saw at it.
    task automatic send_item(input logic func, input t_smp x, input t_smp y, input t_smp z);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {z, y, x};
        do @(posedge clk); while (!s_tready);
    endtask

    // Raw axis value for samples outside a run: mostly random, often an end
    // of the range so that corrections against an extreme bias saturate.
    function automatic t_smp noise_axis();
        case ($urandom_range(0, 7))
            0: return t_smp'(RAW_MIN);
            1: return t_smp'(RAW_MAX);
            default: return t_smp'($urandom);
        endcase
    endfunction

    task automatic send_noise();
        send_item(FUNC_SAMPLE, noise_axis(), noise_axis(), noise_axis());
    endtask

    // The sample fields of a start item are ignored, so they carry garbage.
    task automatic send_start();
        send_item(FUNC_START, t_smp'($urandom), t_smp'($urandom), t_smp'($urandom));
    endtask

    // Takes the sender off the bus, waits until every expected result has
    // come back, then lets the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One phase: write max_spread while nothing is in flight, set the idling
    // pattern, run a full calibration and follow it with idle samples that
    // are corrected with whatever bias the run left behind.
    task automatic calibration_phase(input logic [SPREAD_W-1:0] limit, input t_run_shape shape,
                                     input t_restart restart, input int src_pct,
                                     input int sink_pct);
        int   lo [AXES];
        int   span [AXES];
        int   at_lo [AXES];
        int   at_hi [AXES];
        int   over_axis;
        int   run_items;
        int   aborted;
        int   k;
        t_smp smp [AXES];

        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= limit;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        spread_setting = limit;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;

        // The seed sample and the summed samples all count toward min and max.
        // Each axis hits both ends of its span at two random positions.
        run_items = CAL_SAMPLES + 1;
        over_axis = $urandom_range(0, AXES - 1);
        for (int a = 0; a < AXES; a++) begin
            case (shape)
                RUN_FLAT_EXTREME: begin
                    span[a] = 0;
                    lo[a] = $urandom_range(0, 1) ? RAW_MAX : RAW_MIN;
                end
                RUN_FULL_SWING: begin
                    span[a] = RAW_MAX - RAW_MIN;
                    lo[a] = RAW_MIN;
                end
                default: begin
                    span[a] = spread_setting;
                    if (shape == RUN_OVER && a == over_axis) span[a] = spread_setting + 1;
                    lo[a] = RAW_MIN + int'($urandom_range(0, (RAW_MAX - RAW_MIN) - span[a]));
                end
            endcase
            at_lo[a] = $urandom_range(0, run_items - 1);
            at_hi[a] = (at_lo[a] + int'($urandom_range(1, run_items - 1))) % run_items;
        end

        send_start();
        if (restart == RESTART_EARLY) begin
            repeat ($urandom_range(0, 12)) send_noise();
            send_start();
        end
        // A late restart comes after the seed and all but one summed sample,
        // so the aborted run must neither finish nor touch the bias.
        aborted = (restart == RESTART_LATE) ? CAL_SAMPLES : 0;
        for (int j = 0; j < aborted + run_items; j++) begin
            if (restart == RESTART_LATE && j == aborted) send_start();
            k = (j >= aborted) ? j - aborted : j;
            for (int a = 0; a < AXES; a++) begin
                if (k == at_lo[a]) begin
                    smp[a] = t_smp'(lo[a]);
                end else if (k == at_hi[a]) begin
                    smp[a] = t_smp'(lo[a] + span[a]);
                end else begin
                    smp[a] = t_smp'(lo[a] + int'($urandom_range(0, span[a])));
                end
            end
            send_item(FUNC_SAMPLE, smp[0], smp[1], smp[2]);
        end
        repeat (10) send_noise();
    endtask

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items with zero bias and max_spread at its reset value:
        // range extremes and alternating bit patterns while idle, a start
        // right after a start, a restart right after the seed sample, and a
        // run left in progress for the first phase to start over.
        send_item(FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
        send_item(FUNC_SAMPLE, t_smp'(RAW_MAX), t_smp'(RAW_MIN), -16'sd1);
        send_item(FUNC_SAMPLE, t_smp'(RAW_MIN), t_smp'(RAW_MAX), 16'sd1);
        send_item(FUNC_SAMPLE, 16'h5555, 16'hAAAA, 16'h5555);
        send_item(FUNC_SAMPLE, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_start();
        send_start();
        send_item(FUNC_SAMPLE, 16'sd100, -16'sd100, 16'sd0);
        send_start();
        send_item(FUNC_SAMPLE, t_smp'(RAW_MIN), t_smp'(RAW_MAX), 16'sd7);
        send_item(FUNC_SAMPLE, t_smp'(RAW_MAX), t_smp'(RAW_MIN), -16'sd7);
        send_item(FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
        send_start();
        send_item(FUNC_SAMPLE, 16'hFFFF, 16'h0000, 16'h8000);

        // Phases cover no idling, a slow sender, a slow receiver and both,
        // and max_spread at both ends, at its reset value and at random.
        calibration_phase(16'd0, RUN_FLAT_EXTREME, RESTART_NONE, 0, 0);
        calibration_phase(16'd0, RUN_OVER, RESTART_EARLY, 66, 0);
        calibration_phase(16'hFFFF, RUN_FULL_SWING, RESTART_NONE, 0, 66);
        calibration_phase(16'd256, RUN_WITHIN, RESTART_NONE, 36, 36);
        calibration_phase(16'd256, RUN_OVER, RESTART_LATE, 0, 0);
        calibration_phase(16'($urandom_range(1, 65534)), RUN_WITHIN, RESTART_EARLY, 66, 0);
        calibration_phase(16'hFFFE, RUN_FULL_SWING, RESTART_NONE, 36, 36);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("gyro_bias_calibrate_correct_test: done, clean");
        end else begin
            $display("gyro_bias_calibrate_correct_test: done, errors");
        end
        $finish;
    end

endmodule
